@@ hdl/fsg_pkg.sv @@
package fsg_pkg;

   localparam int GRID_COLS_DEFAULT = 128;
   localparam int GRID_ROWS_DEFAULT = 64;

   localparam logic [9:0]  INTERVAL_RESET = 10'd15;
   localparam logic [15:0] SEED_RESET     = 16'd44257;
   localparam logic [15:0] LFSR_TAPS      = 16'hB400;
   localparam logic [10:0] ELAPSED_MAX    = 11'd2047;

   localparam logic CSR_STEP_INTERVAL = 1'b0;
   localparam logic CSR_RANDOM_SEED   = 1'b1;

   typedef enum logic [1:0] {
      ACT_PLACE = 2'd0,
      ACT_ERASE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_CHECK,
      ST_EMIT,
      SW_HERE,
      SW_BELOW,
      SW_LEFT,
      SW_RIGHT,
      SW_DECIDE,
      SW_MOVE_RD,
      SW_MOVE_WR
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [6:0]  col;
      logic [5:0]  row;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic        hold;
   } req_type;

   typedef struct packed {
      logic        occupied;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic        swept;
   } rsp_type;

endpackage

@@ hdl/fsg_ram.sv @@
module fsg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/falling_sand_grid_engine_unit.sv @@
// Falling-sand grid engine. Each item (place, erase, tick or read) returns exactly one
// result item. Place and read pass through issue, check and emit states around the
// registered read of the cell memories; erase goes from issue straight to emit. A tick
// that triggers a sweep walks every cell of rows 1 and up one at a time through a small
// sequencer around the occupancy memory: an empty cell takes the here and below steps,
// while a grain that checks both diagonals and moves also takes left, right, decide,
// move-read and move-write. After reset the block clears the occupancy memory one cell
// per cycle and holds req_stall high meanwhile; configuration writes are taken at any
// time.
module falling_sand_grid_engine_unit #(
   parameter int GRID_COLS = fsg_pkg::GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = fsg_pkg::GRID_ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsg_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsg_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import fsg_pkg::*;

   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_COLS);

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   logic           inside_ff, inside_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  here_ff, here_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [AW-1:0]  target_ff, target_in;
   logic           left_free_ff, left_free_in;
   logic [10:0]    elapsed_ff, elapsed_in;
   logic [9:0]     interval_ff, interval_in;
   logic [15:0]    lfsr_ff, lfsr_in;
   rsp_type        res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_payload_ff, rsp_payload_in;

   logic           occ_wr_en;
   logic [AW-1:0]  occ_wr_addr;
   logic           occ_wr_data;
   logic [AW-1:0]  occ_rd_addr;
   logic           occ_rd_data;
   logic           color_wr_en;
   logic [AW-1:0]  color_wr_addr;
   logic [23:0]    color_wr_data;
   logic [AW-1:0]  color_rd_addr;
   logic [23:0]    color_rd_data;

   logic [31:0]    idx_full;
   logic [AW-1:0]  below;
   logic [AW-1:0]  below_left;
   logic [AW-1:0]  below_right;
   logic           last_cell;
   logic           advance;
   logic           right_free;
   logic [10:0]    elapsed_bump;

   fsg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_wr_en),
      .wr_addr (occ_wr_addr),
      .wr_data (occ_wr_data),
      .rd_addr (occ_rd_addr),
      .rd_data (occ_rd_data)
   );

   fsg_ram #(.WIDTH(24), .DEPTH(CELLS)) u_color_ram (
      .clock   (clock),
      .wr_en   (color_wr_en),
      .wr_addr (color_wr_addr),
      .wr_data (color_wr_data),
      .rd_addr (color_rd_addr),
      .rd_data (color_rd_data)
   );

   assign idx_full     = 32'(req_payload.row) * 32'(GRID_COLS) + 32'(req_payload.col);
   assign below        = here_ff - AW'(GRID_COLS);
   assign below_left   = below - AW'(1);
   assign below_right  = below + AW'(1);
   assign last_cell    = (here_ff == AW'(CELLS - 1));
   assign elapsed_bump = (elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 11'd1 : elapsed_ff;
   assign right_free   = (col_ff != CW'(GRID_COLS - 1)) && !occ_rd_data;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      inside_in      = inside_ff;
      idx_in         = idx_ff;
      here_in        = here_ff;
      col_in         = col_ff;
      target_in      = target_ff;
      left_free_in   = left_free_ff;
      elapsed_in     = elapsed_ff;
      interval_in    = interval_ff;
      lfsr_in        = lfsr_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      advance        = 1'b0;

      occ_wr_en      = 1'b0;
      occ_wr_addr    = here_ff;
      occ_wr_data    = 1'b0;
      occ_rd_addr    = here_ff;
      color_wr_en    = 1'b0;
      color_wr_addr  = target_ff;
      color_wr_data  = color_rd_data;
      color_rd_addr  = here_ff;

      case (state_ff)
         ST_CLEAR: begin
            occ_wr_en = 1'b1;
            if (last_cell) begin
               state_in = ST_IDLE;
            end else begin
               here_in = here_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_payload;
               inside_in = (32'(req_payload.col) < 32'(GRID_COLS)) &&
                           (32'(req_payload.row) < 32'(GRID_ROWS));
               idx_in    = idx_full[AW-1:0];
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            res_in = '0;
            case (req_ff.action)
               ACT_PLACE, ACT_READ: begin
                  occ_rd_addr   = idx_ff;
                  color_rd_addr = idx_ff;
                  state_in      = ST_CHECK;
               end
               ACT_ERASE: begin
                  occ_wr_en   = inside_ff;
                  occ_wr_addr = idx_ff;
                  occ_wr_data = 1'b0;
                  state_in    = ST_EMIT;
               end
               ACT_TICK: begin
                  if ((elapsed_bump > {1'b0, interval_ff}) && !req_ff.hold) begin
                     elapsed_in = '0;
                     here_in    = AW'(GRID_COLS);
                     col_in     = '0;
                     state_in   = SW_HERE;
                  end else begin
                     elapsed_in = elapsed_bump;
                     state_in   = ST_EMIT;
                  end
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_CHECK: begin
            if (req_ff.action == ACT_PLACE) begin
               occ_wr_en     = inside_ff && !occ_rd_data;
               occ_wr_addr   = idx_ff;
               occ_wr_data   = 1'b1;
               color_wr_en   = inside_ff && !occ_rd_data;
               color_wr_addr = idx_ff;
               color_wr_data = {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
            end else if (inside_ff && occ_rd_data) begin
               res_in.occupied  = 1'b1;
               res_in.red_out   = color_rd_data[23:16];
               res_in.green_out = color_rd_data[15:8];
               res_in.blue_out  = color_rd_data[7:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in = res_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         SW_HERE: begin
            occ_rd_addr = here_ff;
            state_in    = SW_BELOW;
         end
         SW_BELOW: begin
            if (!occ_rd_data) begin
               advance = 1'b1;
            end else begin
               occ_rd_addr = below;
               state_in    = SW_LEFT;
            end
         end
         SW_LEFT: begin
            if (!occ_rd_data) begin
               target_in = below;
               state_in  = SW_MOVE_RD;
            end else begin
               occ_rd_addr = below_left;
               state_in    = SW_RIGHT;
            end
         end
         SW_RIGHT: begin
            // In column zero the below-left address wraps to the end of another row; the result is masked.
            left_free_in = (col_ff != '0) && !occ_rd_data;
            occ_rd_addr  = below_right;
            state_in     = SW_DECIDE;
         end
         SW_DECIDE: begin
            if (left_free_ff && right_free) begin
               lfsr_in   = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
               target_in = lfsr_ff[0] ? below_left : below_right;
               state_in  = SW_MOVE_RD;
            end else if (left_free_ff) begin
               target_in = below_left;
               state_in  = SW_MOVE_RD;
            end else if (right_free) begin
               target_in = below_right;
               state_in  = SW_MOVE_RD;
            end else begin
               advance = 1'b1;
            end
         end
         SW_MOVE_RD: begin
            occ_wr_en     = 1'b1;
            occ_wr_addr   = here_ff;
            occ_wr_data   = 1'b0;
            color_rd_addr = here_ff;
            state_in      = SW_MOVE_WR;
         end
         SW_MOVE_WR: begin
            occ_wr_en     = 1'b1;
            occ_wr_addr   = target_ff;
            occ_wr_data   = 1'b1;
            color_wr_en   = 1'b1;
            color_wr_addr = target_ff;
            color_wr_data = color_rd_data;
            advance       = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (last_cell) begin
            res_in.swept = 1'b1;
            state_in     = ST_EMIT;
         end else begin
            here_in  = here_ff + AW'(1);
            col_in   = (col_ff == CW'(GRID_COLS - 1)) ? '0 : col_ff + CW'(1);
            state_in = SW_HERE;
         end
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_INTERVAL: interval_in = csr_wdata[9:0];
            CSR_RANDOM_SEED:   lfsr_in     = csr_wdata;
            default:           interval_in = interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         here_ff      <= '0;
         col_ff       <= '0;
         elapsed_ff   <= '0;
         interval_ff  <= INTERVAL_RESET;
         lfsr_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         here_ff      <= here_in;
         col_ff       <= col_in;
         elapsed_ff   <= elapsed_in;
         interval_ff  <= interval_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      inside_ff      <= inside_in;
      idx_ff         <= idx_in;
      target_ff      <= target_in;
      left_free_ff   <= left_free_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result item offered during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.swept) |-> !rsp_payload_ff.occupied)
      else $error("sweep result also reports a cell read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.occupied) |->
         (rsp_payload_ff.red_out == 8'd0 && rsp_payload_ff.green_out == 8'd0 &&
          rsp_payload_ff.blue_out == 8'd0))
      else $error("empty cell result carries a colour");

   assert property (@(posedge clock) disable iff (reset)
      (lfsr_ff != 16'd0 && !csr_wr_en) |=> (lfsr_ff != 16'd0))
      else $error("nonzero LFSR state stepped to zero");

endmodule

@@ tb/sv/falling_sand_grid_engine_unit_tb.sv @@
module falling_sand_grid_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsg_pkg::*;

   localparam int COLS = GRID_COLS_DEFAULT;
   localparam int ROWS = GRID_ROWS_DEFAULT;
   localparam int CELLS = COLS * ROWS;
   // The idle limit leaves room for a full sweep of a crowded grid and for the clear after reset.
   localparam int IDLE_LIMIT = 200000;
   localparam int PRESSURE_CYCLES = 300;

   typedef struct {
      req_type     item;
      int unsigned repeats;
      bit          known;
      rsp_type     expected;
   } stim_row_type;

   typedef struct {
      logic [9:0]  ticks_needed;
      logic [15:0] seed;
      int          items;
      int          window;
      bit          calm;
      int          burst;
   } phase_plan_type;

   localparam rsp_type NO_DATA = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_STEP_INTERVAL;
   logic [15:0] csr_wdata = '0;

   // Shadow copy of the grid and of the sweep controls.
   bit          grain_map [CELLS];
   logic [23:0] grain_rgb [CELLS];
   logic [15:0] lfsr_q = SEED_RESET;
   logic [10:0] tick_count = '0;
   logic [9:0]  interval_q = INTERVAL_RESET;

   rsp_type     awaited_results[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;

   falling_sand_grid_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic req_type mk_req(action_type act, int col, int row,
                                      logic [23:0] rgb, bit hold);
      req_type r;
      r.action   = act;
      r.col      = col[6:0];
      r.row      = row[5:0];
      r.red_in   = rgb[23:16];
      r.green_in = rgb[15:8];
      r.blue_in  = rgb[7:0];
      r.hold     = hold;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(bit occupied, logic [23:0] rgb, bit swept);
      rsp_type r;
      r.occupied  = occupied;
      r.red_out   = rgb[23:16];
      r.green_out = rgb[15:8];
      r.blue_out  = rgb[7:0];
      r.swept     = swept;
      return r;
   endfunction

   function automatic rsp_type predict_grid_item(req_type item);
      rsp_type res;
      int      here;
      int      below;
      int      spot;
      bit      left_free;
      bit      right_free;
      res = '0;
      here = int'(item.row) * COLS + int'(item.col);
      case (item.action)
         ACT_PLACE: begin
            if (!grain_map[here]) begin
               grain_map[here] = 1'b1;
               grain_rgb[here] = {item.red_in, item.green_in, item.blue_in};
            end
         end
         ACT_ERASE: begin
            grain_map[here] = 1'b0;
         end
         ACT_TICK: begin
            if (tick_count != ELAPSED_MAX) tick_count++;
            if (tick_count > {1'b0, interval_q} && !item.hold) begin
               tick_count = '0;
               res.swept = 1'b1;
               // Bottom row is never visited, so grains resting there stay put.
               for (int r = 1; r < ROWS; r++) begin
                  for (int c = 0; c < COLS; c++) begin
                     here = r * COLS + c;
                     below = here - COLS;
                     if (grain_map[here]) begin
                        left_free  = (c > 0) && !grain_map[below - 1];
                        right_free = (c < COLS - 1) && !grain_map[below + 1];
                        spot = here;
                        if (!grain_map[below]) begin
                           spot = below;
                        end else if (left_free && right_free) begin
                           // The random bit is drawn only when both diagonals are open.
                           spot = lfsr_q[0] ? below - 1 : below + 1;
                           lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);
                        end else if (left_free) begin
                           spot = below - 1;
                        end else if (right_free) begin
                           spot = below + 1;
                        end
                        if (spot != here) begin
                           grain_map[here] = 1'b0;
                           grain_map[spot] = 1'b1;
                           grain_rgb[spot] = grain_rgb[here];
                        end
                     end
                  end
               end
            end
         end
         default: begin
            if (grain_map[here]) begin
               res.occupied = 1'b1;
               {res.red_out, res.green_out, res.blue_out} = grain_rgb[here];
            end
         end
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Most items land in a small window near the bottom so that grains pile up.
   function automatic req_type random_item(int window);
      req_type item;
      int      roll;
      roll = $urandom_range(0, 99);
      item = mk_req(ACT_TICK, $urandom_range(0, 127), $urandom_range(0, 63),
                    24'($urandom), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
         item.col = 7'(window + $urandom_range(0, 7));
         item.row = 6'($urandom_range(0, 5));
      end
      if (roll < 35) item.action = ACT_PLACE;
      else if (roll < 45) item.action = ACT_ERASE;
      else if (roll < 75) item.action = ACT_READ;
      return item;
   endfunction

   task automatic send_item(input req_type item, input bit known, input rsp_type typed);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_grid_item(item);
      awaited_results.push_back(known ? typed : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input logic [9:0] ticks_needed, input logic [15:0] seed);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STEP_INTERVAL;
      csr_wdata <= {6'd0, ticks_needed};
      @(posedge clock);
      interval_q = ticks_needed;
      csr_index <= CSR_RANDOM_SEED;
      csr_wdata <= seed;
      @(posedge clock);
      lfsr_q = seed;
      csr_wr_en <= 1'b0;
   endtask

   // Result side: random stalls, plus two long hold-offs that back up the input.
   initial begin
      int      hold_left;
      bit [1:0] pressed;
      rsp_type want;
      hold_left = 0;
      pressed = '0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.occupied !== want.occupied) begin
                  $error("occupied: expected %0d, got %0d", want.occupied,
                         rsp_payload.occupied);
                  mismatches++;
               end
               if (rsp_payload.red_out !== want.red_out) begin
                  $error("red_out: expected %0h, got %0h", want.red_out,
                         rsp_payload.red_out);
                  mismatches++;
               end
               if (rsp_payload.green_out !== want.green_out) begin
                  $error("green_out: expected %0h, got %0h", want.green_out,
                         rsp_payload.green_out);
                  mismatches++;
               end
               if (rsp_payload.blue_out !== want.blue_out) begin
                  $error("blue_out: expected %0h, got %0h", want.blue_out,
                         rsp_payload.blue_out);
                  mismatches++;
               end
               if (rsp_payload.swept !== want.swept) begin
                  $error("swept: expected %0d, got %0d", want.swept, rsp_payload.swept);
                  mismatches++;
               end
            end
         end
         if (hold_left == 0) begin
            if (!pressed[0] && results_seen >= 3) begin
               pressed[0] = 1'b1;
               hold_left = PRESSURE_CYCLES;
            end else if (!pressed[1] && results_seen >= 70) begin
               pressed[1] = 1'b1;
               hold_left = PRESSURE_CYCLES;
            end else begin
               hold_left = pick_gap();
            end
         end
         rsp_stall <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      stim_row_type   directed[$];
      phase_plan_type plans[4];

      directed.push_back('{mk_req(ACT_READ, 0, 0, 24'h000000, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 127, 63, 24'h000000, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 0, 0, 24'hFFFFFF, 1), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 0, 0, 24'h000000, 0), 1, 1'b1,
                           mk_rsp(1'b1, 24'hFFFFFF, 1'b0)});
      // Placing onto a taken cell keeps the first colour.
      directed.push_back('{mk_req(ACT_PLACE, 0, 0, 24'h000000, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 0, 0, 24'h000000, 0), 1, 1'b1,
                           mk_rsp(1'b1, 24'hFFFFFF, 1'b0)});
      directed.push_back('{mk_req(ACT_PLACE, 127, 63, 24'h123456, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 127, 63, 24'h000000, 0), 1, 1'b1,
                           mk_rsp(1'b1, 24'h123456, 1'b0)});
      directed.push_back('{mk_req(ACT_ERASE, 127, 63, 24'h000000, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_ERASE, 127, 63, 24'h000000, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 127, 63, 24'h000000, 0), 1, 1'b1, NO_DATA});
      // Left edge, right edge and an open spot where both diagonals are free.
      directed.push_back('{mk_req(ACT_PLACE, 0, 1, 24'h80017F, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 1, 1, 24'h0180FE, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 127, 0, 24'h55AA00, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 127, 1, 24'hAA55FF, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 64, 0, 24'h0FF03C, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_PLACE, 64, 1, 24'hC33C81, 0), 1, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_TICK, 0, 0, 24'h000000, 1), 15, 1'b1, NO_DATA});
      directed.push_back('{mk_req(ACT_TICK, 0, 0, 24'h000000, 0), 1, 1'b1,
                           mk_rsp(1'b0, 24'h000000, 1'b1)});
      directed.push_back('{mk_req(ACT_READ, 1, 0, 24'h000000, 0), 1, 1'b0, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 2, 0, 24'h000000, 0), 1, 1'b0, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 126, 0, 24'h000000, 0), 1, 1'b0, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 63, 0, 24'h000000, 0), 1, 1'b0, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 64, 1, 24'h000000, 0), 1, 1'b0, NO_DATA});
      directed.push_back('{mk_req(ACT_READ, 0, 0, 24'h000000, 0), 1, 1'b0, NO_DATA});

      // The second phase ends with a run of held ticks that carries the elapsed
      // count past the interval before one released tick.
      plans[0] = '{10'd0, 16'h0000, 15, 0, 1'b0, 0};
      plans[1] = '{10'd7, 16'hFFFF, 10, 120, 1'b0, 8};
      plans[2] = '{10'd3, 16'h0001, 15, $urandom_range(8, 112), 1'b1, 0};
      plans[3] = '{10'($urandom_range(0, 7)), 16'($urandom_range(1, 65535)), 20, 60,
                   1'b0, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         for (int n = 0; n < directed[i].repeats; n++) begin
            send_item(directed[i].item, directed[i].known, directed[i].expected);
         end
      end
      drain();

      foreach (plans[p]) begin
         load_config(plans[p].ticks_needed, plans[p].seed);
         quiet = plans[p].calm;
         for (int n = 0; n < plans[p].items; n++) begin
            send_item(random_item(plans[p].window), 1'b0, NO_DATA);
         end
         for (int n = 0; n < plans[p].burst; n++) begin
            send_item(mk_req(ACT_TICK, $urandom_range(0, 127), $urandom_range(0, 63),
                             24'($urandom), 1'b1), 1'b0, NO_DATA);
         end
         if (plans[p].burst > 0) begin
            send_item(mk_req(ACT_TICK, 0, 0, 24'h000000, 1'b0), 1'b0, NO_DATA);
         end
         drain();
         quiet = 1'b0;
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
